/* hw/rtl/uds_dtc_report_responder_macros.svh */
// Assertion macros shared by the responder RTL.
`ifndef UDS_DTC_REPORT_RESPONDER_MACROS_SVH
`define UDS_DTC_REPORT_RESPONDER_MACROS_SVH

`ifndef ASSERT_OFF
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

/* hw/rtl/dtc_pkg.sv */
`default_nettype none

package dtc_pkg;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_PUSH2,
    ST_PUSH1
  } state_t;

  typedef enum logic [1:0] {
    OP_NONE,
    OP_COUNT,
    OP_LIST,
    OP_FIND
  } op_t;

  typedef struct packed {
    logic [1:0] status;
    logic [2:0] count;
    logic [7:0] b0;
    logic [7:0] b1;
    logic [7:0] b2;
    logic [7:0] b3;
    logic       last;
  } resp_t;

  localparam logic [1:0] RS_POS      = 2'd0;
  localparam logic [1:0] RS_UNSUP    = 2'd1;
  localparam logic [1:0] RS_LENGTH   = 2'd2;
  localparam logic [1:0] RS_RANGE    = 2'd3;

  localparam logic [6:0] SF_COUNT    = 7'd1;
  localparam logic [6:0] SF_LIST     = 7'd2;
  localparam logic [6:0] SF_IDENT    = 7'd3;
  localparam logic [6:0] SF_FIND     = 7'd4;

  localparam logic [11:0] LEN_MASK   = 12'd3;
  localparam logic [11:0] LEN_IDENT  = 12'd2;
  localparam logic [11:0] LEN_FIND   = 12'd6;

  localparam logic [7:0] POS_SID     = 8'h59;
  localparam logic [7:0] FORMAT_ID   = 8'h01;

  localparam int RC_W = 6;
  localparam logic [RC_W-1:0] MAX_RESULTS = 6'd33;

endpackage

`default_nettype wire

/* hw/rtl/dtc_if.sv */
`default_nettype none

interface dtc_req_if;
  logic        valid;
  logic        ready;
  logic        req_type;
  logic [4:0]  entry_index;
  logic [7:0]  entry_channel;
  logic [23:0] entry_code;
  logic [7:0]  entry_status;
  logic [11:0] req_length;
  logic [7:0]  req_sub_function;
  logic [7:0]  req_byte2;
  logic [7:0]  req_byte3;
  logic [7:0]  req_byte4;
  logic [7:0]  req_byte5;

  modport source (
    output valid, req_type, entry_index, entry_channel, entry_code, entry_status,
           req_length, req_sub_function, req_byte2, req_byte3, req_byte4, req_byte5,
    input  ready
  );
  modport sink (
    input  valid, req_type, entry_index, entry_channel, entry_code, entry_status,
           req_length, req_sub_function, req_byte2, req_byte3, req_byte4, req_byte5,
    output ready
  );
endinterface

interface dtc_resp_if;
  logic       valid;
  logic       ready;
  logic [1:0] resp_status;
  logic [2:0] byte_count;
  logic [7:0] resp_byte0;
  logic [7:0] resp_byte1;
  logic [7:0] resp_byte2;
  logic [7:0] resp_byte3;
  logic       resp_last;

  modport source (
    output valid, resp_status, byte_count, resp_byte0, resp_byte1, resp_byte2,
           resp_byte3, resp_last,
    input  ready
  );
  modport sink (
    input  valid, resp_status, byte_count, resp_byte0, resp_byte1, resp_byte2,
           resp_byte3, resp_last,
    output ready
  );
endinterface

`default_nettype wire

/* hw/rtl/uds_dtc_report_responder.sv */
// A write request is stored when it is accepted and the block stays idle; a request
// without a table lookup passes through ST_PUSH1 into the output register. A counting,
// listing or lookup request scans the table memory one entry per cycle, holding on a
// listed match while the response side stalls; listed results leave during the scan.
// Synchronous active-high reset clears the occupied flags, the state and the output valid
// flag at once and sets the availability mask to 0xFF; there is no clearing pass.
`default_nettype none
`include "uds_dtc_report_responder_macros.svh"

module uds_dtc_report_responder
  import dtc_pkg::*;
#(
  parameter int TABLE_ENTRIES = 32
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       cfg_wr_en,
  input  wire logic [7:0] cfg_wr_data,
  dtc_req_if.sink         req,
  dtc_resp_if.source      resp
);

  localparam int AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int IW = $clog2(TABLE_ENTRIES + 1);
  localparam logic [IW-1:0] LAST_CNT = IW'(TABLE_ENTRIES);

  state_t            state, state_next;
  op_t               op;
  logic [7:0]        avail;
  logic [7:0]        mask;
  logic [7:0]        mid;
  logic [7:0]        lo;
  logic [7:0]        rec;
  resp_t             held;
  logic [RC_W-1:0]   n_res;
  logic [IW-1:0]     cnt;
  logic [IW-1:0]     iss_cnt;
  logic              rd_valid;
  logic              rd_occ;
  logic [31:0]       rd_word;
  logic [31:0]       mem [TABLE_ENTRIES];
  logic [TABLE_ENTRIES-1:0] occ;
  logic              out_valid;
  resp_t             out_data;

  logic              acc;
  logic              wr_en;
  logic [5:0]        widx_ext;
  logic [AW-1:0]     waddr;
  logic [AW-1:0]     raddr;
  logic [6:0]        sub;
  logic              mask_ok;
  logic              out_free;
  logic              match_cov;
  logic              match_code;
  logic              list_push;
  logic              proc;
  logic              found;
  logic              more;
  logic              issue;
  logic              scan_done;
  logic              push;
  resp_t             push_data;
  op_t               acc_op;
  resp_t             acc_held;
  state_t            acc_state;
  logic [15:0]       cnt16;

  function automatic resp_t mk(input logic [1:0] st, input logic [2:0] c,
                               input logic [7:0] b0, input logic [7:0] b1,
                               input logic [7:0] b2, input logic [7:0] b3,
                               input logic l);
    resp_t r;
    r.status = st;
    r.count  = c;
    r.b0     = b0;
    r.b1     = b1;
    r.b2     = b2;
    r.b3     = b3;
    r.last   = l;
    return r;
  endfunction

  assign acc      = req.valid && req.ready;
  assign req.ready = (state == ST_IDLE);
  assign wr_en    = acc && !req.req_type && ({1'b0, req.entry_index} < 6'(TABLE_ENTRIES));
  assign widx_ext = {1'b0, req.entry_index};
  assign waddr    = widx_ext[AW-1:0];
  assign raddr    = iss_cnt[AW-1:0];
  assign sub      = req.req_sub_function[6:0];
  assign mask_ok  = ((avail & req.req_byte2) == req.req_byte2);
  assign out_free = !out_valid || resp.ready;
  assign cnt16    = 16'(cnt);

  assign match_cov  = rd_occ && ((rd_word[7:0] & mask) == mask);
  assign match_code = rd_occ && (rd_word[31:8] == {mask, mid, lo});
  assign list_push  = (state == ST_SCAN) && (op == OP_LIST) && rd_valid && match_cov &&
                      (n_res < MAX_RESULTS);
  assign proc       = (state == ST_SCAN) && rd_valid && (!list_push || out_free);
  assign found      = proc && (op == OP_FIND) && match_code;
  assign more       = (iss_cnt < LAST_CNT);
  assign issue      = (state == ST_SCAN) && more && (!rd_valid || proc) && !found;
  assign scan_done  = (state == ST_SCAN) && !more && (!rd_valid || proc) && !found;

  always_comb begin
    acc_op    = OP_NONE;
    acc_state = ST_PUSH1;
    acc_held  = mk(RS_LENGTH, 3'd0, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0);
    unique case (sub)
      SF_COUNT: begin
        if (req.req_length == LEN_MASK) begin
          if (mask_ok) begin
            acc_op    = OP_COUNT;
            acc_state = ST_SCAN;
          end else begin
            acc_held = mk(RS_RANGE, 3'd0, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0);
          end
        end
      end
      SF_LIST: begin
        if (req.req_length == LEN_MASK) begin
          acc_held = mk(RS_POS, 3'd3, POS_SID, {1'b0, SF_LIST}, avail, 8'h00, 1'b0);
          if (mask_ok) begin
            acc_op    = OP_LIST;
            acc_state = ST_SCAN;
          end
        end
      end
      SF_IDENT: begin
        if (req.req_length == LEN_IDENT) begin
          acc_held = mk(RS_POS, 3'd2, POS_SID, {1'b0, SF_IDENT}, 8'h00, 8'h00, 1'b0);
        end
      end
      SF_FIND: begin
        if (req.req_length == LEN_FIND) begin
          acc_op    = OP_FIND;
          acc_state = ST_SCAN;
        end
      end
      default: begin
        acc_held = mk(RS_UNSUP, 3'd0, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0);
      end
    endcase
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (acc && req.req_type) begin
          state_next = acc_state;
        end
      end
      ST_SCAN: begin
        priority if (found) begin
          state_next = ST_PUSH2;
        end else if (scan_done) begin
          state_next = (op == OP_COUNT) ? ST_PUSH2 : ST_PUSH1;
        end
      end
      ST_PUSH2: begin
        if (out_free) begin
          state_next = ST_PUSH1;
        end
      end
      ST_PUSH1: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    push      = 1'b0;
    push_data = held;
    unique case (state)
      ST_SCAN: begin
        push           = list_push && out_free;
        push_data      = held;
        push_data.last = 1'b0;
      end
      ST_PUSH2: begin
        push = out_free;
        if (op == OP_COUNT) begin
          push_data = mk(RS_POS, 3'd4, POS_SID, {1'b0, SF_COUNT}, avail, FORMAT_ID, 1'b0);
        end else begin
          push_data = mk(RS_POS, 3'd4, POS_SID, {1'b0, SF_FIND}, mask, mid, 1'b0);
        end
      end
      ST_PUSH1: begin
        push = out_free;
        if (op == OP_COUNT) begin
          push_data = mk(RS_POS, 3'd2, cnt16[15:8], cnt16[7:0], 8'h00, 8'h00, 1'b1);
        end else begin
          push_data      = held;
          push_data.last = 1'b1;
        end
      end
      default: begin
        push = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[waddr] <= {req.entry_code, req.entry_status};
    end
    if (issue) begin
      rd_word <= mem[raddr];
      rd_occ  <= occ[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      occ       <= '0;
      avail     <= 8'hFF;
      state     <= ST_IDLE;
      rd_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (wr_en) begin
        occ[waddr] <= (req.entry_channel != 8'h00);
      end
      if (cfg_wr_en) begin
        avail <= cfg_wr_data;
      end
      if (acc) begin
        rd_valid <= 1'b0;
      end else if (issue) begin
        rd_valid <= 1'b1;
      end else if (proc) begin
        rd_valid <= 1'b0;
      end
      if (push) begin
        out_valid <= 1'b1;
      end else if (resp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      out_data <= push_data;
    end
    if (acc && req.req_type) begin
      op      <= acc_op;
      held    <= acc_held;
      mask    <= req.req_byte2;
      mid     <= req.req_byte3;
      lo      <= req.req_byte4;
      rec     <= req.req_byte5;
      n_res   <= RC_W'(1);
      cnt     <= '0;
      iss_cnt <= '0;
    end else begin
      if (issue) begin
        iss_cnt <= iss_cnt + IW'(1);
      end
      if (proc && (op == OP_COUNT) && match_cov) begin
        cnt <= cnt + IW'(1);
      end
      if (list_push && out_free) begin
        held  <= mk(RS_POS, 3'd4, rd_word[31:24], rd_word[23:16], 8'h00, rd_word[7:0],
                    1'b0);
        n_res <= n_res + RC_W'(1);
      end
      if (found) begin
        held <= mk(RS_POS, 3'd3, lo, rd_word[7:0], rec, 8'h00, 1'b0);
      end else if (scan_done && (op == OP_FIND)) begin
        held <= mk(RS_RANGE, 3'd0, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0);
      end
    end
  end

  assign resp.valid       = out_valid;
  assign resp.resp_status = out_data.status;
  assign resp.byte_count  = out_data.count;
  assign resp.resp_byte0  = out_data.b0;
  assign resp.resp_byte1  = out_data.b1;
  assign resp.resp_byte2  = out_data.b2;
  assign resp.resp_byte3  = out_data.b3;
  assign resp.resp_last   = out_data.last;

  `ASSERT_IMPLIES(a_idle_no_read, clk, rst, req.ready, !rd_valid)
  `ASSERT_IMPLIES(a_negative_last, clk, rst,
                  resp.valid && (resp.resp_status != RS_POS), resp.resp_last)
  `ASSERT_NEXT(a_write_stays_idle, clk, rst, acc && !req.req_type, req.ready)

endmodule

`default_nettype wire
